// ----- rtl/e2q_pkg.sv -----
`timescale 1ns / 1ps

package e2q_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int QUAT_BITS    = 16;
  localparam int HALF_SHIFT   = 33 - ANGLE_BITS;
  localparam int QUAT_FRAC    = QUAT_BITS - 2;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = QUAT_FRAC + 1;

  // half angle Q30, |theta| <= 2^32
  localparam int THETA_W = 35;
  localparam int Z_W     = 33;
  localparam int XY_W    = 32;
  localparam int TRIG_W  = 30;
  localparam int PROD1_W = 31;
  localparam int MUL2_W  = PROD1_W + TRIG_W;
  localparam int Q_W     = 32;
  localparam int SUM_W   = 64;
  localparam int NORM_W  = 32;
  localparam int QUO_W   = QUAT_FRAC + 1;

  localparam logic signed [THETA_W-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [THETA_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [QUAT_BITS-1:0] Q_ONE     = QUAT_BITS'(1 << QUAT_FRAC);

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
  } angles_t;

  typedef struct packed {
    logic signed [QUAT_BITS-1:0] quat_w;
    logic signed [QUAT_BITS-1:0] quat_x;
    logic signed [QUAT_BITS-1:0] quat_y;
    logic signed [QUAT_BITS-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
  } trig_t;

  // atan(2^-i) * 2^30, truncated
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/e2q_cordic.sv -----
`timescale 1ns / 1ps

// Half-angle cosine/sine: range reduction, one CORDIC iteration per stage,
// sign fix-up.
module e2q_cordic (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0]  angle,
  output logic                                   out_valid,
  output e2q_pkg::trig_t                         trig
);

  localparam int N  = e2q_pkg::CORDIC_STEPS;
  localparam int TW = e2q_pkg::THETA_W;
  localparam int ZW = e2q_pkg::Z_W;
  localparam int XW = e2q_pkg::XY_W;
  localparam int EXT = TW - e2q_pkg::ANGLE_BITS - e2q_pkg::HALF_SHIFT;

  logic signed [TW-1:0] theta;
  logic signed [TW-1:0] theta_red;
  logic                 neg_red;

  logic signed [XW-1:0] xs [N+1];
  logic signed [XW-1:0] ys [N+1];
  logic signed [ZW-1:0] zs [N+1];
  logic [N:0]           negs;
  logic [N:0]           vs;

  always_comb begin
    theta = {{EXT{angle[e2q_pkg::ANGLE_BITS-1]}}, angle, {e2q_pkg::HALF_SHIFT{1'b0}}};
    if (theta > e2q_pkg::HALF_PI_Q30) begin
      theta_red = theta - e2q_pkg::PI_Q30;
      neg_red   = 1'b1;
    end else if (theta < -e2q_pkg::HALF_PI_Q30) begin
      theta_red = theta + e2q_pkg::PI_Q30;
      neg_red   = 1'b1;
    end else begin
      theta_red = theta;
      neg_red   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    xs[0]   <= XW'(1 << 28);
    ys[0]   <= '0;
    zs[0]   <= theta_red[ZW-1:0];
    negs[0] <= neg_red;
    for (int i = 0; i < N; i++) begin
      negs[i+1] <= negs[i];
      if (!zs[i][ZW-1]) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - signed'({1'b0, e2q_pkg::atan_q30(5'(i))});
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + signed'({1'b0, e2q_pkg::atan_q30(5'(i))});
      end
    end
    trig.c <= negs[N] ? -xs[N][e2q_pkg::TRIG_W-1:0] : xs[N][e2q_pkg::TRIG_W-1:0];
    trig.s <= negs[N] ? -ys[N][e2q_pkg::TRIG_W-1:0] : ys[N][e2q_pkg::TRIG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs        <= '0;
      out_valid <= 1'b0;
    end else begin
      vs        <= {vs[N-1:0], in_valid};
      out_valid <= vs[N];
    end
  end

endmodule

// ----- rtl/euler_to_quaternion.sv -----
`timescale 1ns / 1ps

// ZYX Euler angles to unit quaternion. Roll, pitch and yaw (signed Q3.12
// radians) enter as one transaction when start is high; busy is always low,
// so a new transaction may be offered every clock. Each result appears on
// quat for exactly one cycle with done high; the receiver must take it
// then, there is no back-pressure. The pipeline is made of the fully
// pipelined units: half-angle CORDIC, product tree, sum of squares, square
// root at one result bit per stage, dividend set-up, restoring divide at
// one quotient bit per stage over QUAT_BITS-1 quotient bits and the output
// register. Components are normalised by the rounded quotient against the
// integer root of the sum of squares and saturated to +-1 in Q1.14. No
// state is kept between transactions.
module euler_to_quaternion (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  e2q_pkg::angles_t angles,
  output logic             done,
  output e2q_pkg::quat_t   quat
);

  localparam int TW  = e2q_pkg::TRIG_W;
  localparam int P1W = e2q_pkg::PROD1_W;
  localparam int M2W = e2q_pkg::MUL2_W;
  localparam int QW  = e2q_pkg::Q_W;
  localparam int SW  = e2q_pkg::SUM_W;
  localparam int NW  = e2q_pkg::NORM_W;
  localparam int QB  = e2q_pkg::QUAT_BITS;
  localparam int QF  = e2q_pkg::QUAT_FRAC;
  localparam int UW  = e2q_pkg::QUO_W;
  localparam int RS  = e2q_pkg::SQRT_STEPS;
  localparam int DS  = e2q_pkg::DIV_STEPS;

  // no back-pressure anywhere
  assign busy = 1'b0;

  // ---- half-angle cos/sin, three lanes
  e2q_pkg::trig_t tr_r, tr_p, tr_y;
  logic           cv_r, cv_p, cv_y;

  e2q_cordic u_cordic_roll (
    .clk(clk), .rst(rst), .in_valid(start), .angle(angles.roll_angle),
    .out_valid(cv_r), .trig(tr_r)
  );
  e2q_cordic u_cordic_pitch (
    .clk(clk), .rst(rst), .in_valid(start), .angle(angles.pitch_angle),
    .out_valid(cv_p), .trig(tr_p)
  );
  e2q_cordic u_cordic_yaw (
    .clk(clk), .rst(rst), .in_valid(start), .angle(angles.yaw_angle),
    .out_valid(cv_y), .trig(tr_y)
  );

  // ---- product tree
  logic signed [2*TW-1:0] pa, pb, pc, pd;
  logic signed [P1W-1:0]  a1, b1, c1, d1;
  logic signed [TW-1:0]   cr1, sr1;
  logic signed [M2W-1:0]  mw [8];
  logic signed [M2W-1:0]  m2 [8];
  logic signed [M2W:0]    tq [4];
  logic signed [QW-1:0]   q3 [4];

  always_comb begin
    pa = tr_y.c * tr_p.c;
    pb = tr_y.s * tr_p.s;
    pc = tr_y.s * tr_p.c;
    pd = tr_y.c * tr_p.s;
    mw[0] = a1 * cr1;
    mw[1] = b1 * sr1;
    mw[2] = a1 * sr1;
    mw[3] = b1 * cr1;
    mw[4] = c1 * sr1;
    mw[5] = d1 * cr1;
    mw[6] = c1 * cr1;
    mw[7] = d1 * sr1;
    tq[0] = (M2W+1)'(m2[0]) + (M2W+1)'(m2[1]);
    tq[1] = (M2W+1)'(m2[2]) - (M2W+1)'(m2[3]);
    tq[2] = (M2W+1)'(m2[4]) + (M2W+1)'(m2[5]);
    tq[3] = (M2W+1)'(m2[6]) - (M2W+1)'(m2[7]);
  end

  always_ff @(posedge clk) begin
    a1  <= P1W'(pa >>> 28);
    b1  <= P1W'(pb >>> 28);
    c1  <= P1W'(pc >>> 28);
    d1  <= P1W'(pd >>> 28);
    cr1 <= tr_r.c;
    sr1 <= tr_r.s;
    m2  <= mw;
    for (int k = 0; k < 4; k++) begin
      q3[k] <= QW'(tq[k] >>> 28);
    end
  end

  // ---- sum of squares
  logic signed [SW-1:0] sqw [4];
  logic [SW-1:0]        sq1 [4];
  logic signed [QW-1:0] qs1 [4];
  logic [SW-1:0]        ps2 [2];
  logic signed [QW-1:0] qs2 [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sqw[k] = q3[k] * q3[k];
    end
  end

  // ---- integer square root, one result bit per stage
  logic [SW-1:0]        rn [RS+1];
  logic [SW-1:0]        rr [RS+1];
  logic signed [QW-1:0] qsq [RS+1][4];
  logic [SW-1:0]        trial [RS];

  always_comb begin
    for (int k = 0; k < RS; k++) begin
      trial[k] = rr[k] + (SW'(1) << (62 - 2 * k));
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      sq1[k] <= sqw[k];
      qs1[k] <= q3[k];
      qs2[k] <= qs1[k];
    end
    ps2[0] <= sq1[0] + sq1[1];
    ps2[1] <= sq1[2] + sq1[3];
    rn[0]  <= ps2[0] + ps2[1];
    rr[0]  <= '0;
    qsq[0] <= qs2;
    for (int k = 0; k < RS; k++) begin
      qsq[k+1] <= qsq[k];
      if (rn[k] >= trial[k]) begin
        rn[k+1] <= rn[k] - trial[k];
        rr[k+1] <= (rr[k] >> 1) + (SW'(1) << (62 - 2 * k));
      end else begin
        rn[k+1] <= rn[k];
        rr[k+1] <= rr[k] >> 1;
      end
    end
  end

  // ---- restoring divide, one quotient bit per stage, four lanes
  logic [NW-1:0] norm;
  logic [SW-1:0] rem [DS+1][4];
  logic [UW-1:0] quo [DS+1][4];
  logic [3:0]    dneg [DS+1];
  logic [NW-1:0] dn [DS+1];
  logic [DS:0]   dzero;
  logic [QW-1:0] mag [4];
  logic [SW-1:0] dsh [DS];

  always_comb begin
    norm = rr[RS][NW-1:0];
    for (int k = 0; k < 4; k++) begin
      mag[k] = qsq[RS][k][QW-1] ? QW'(-qsq[RS][k]) : QW'(qsq[RS][k]);
    end
    for (int j = 0; j < DS; j++) begin
      dsh[j] = SW'(dn[j]) << (QF - j);
    end
  end

  always_ff @(posedge clk) begin
    dn[0]    <= norm;
    dzero[0] <= (norm == '0);
    for (int k = 0; k < 4; k++) begin
      rem[0][k]  <= (SW'(mag[k]) << QF) + SW'(norm >> 1);
      quo[0][k]  <= '0;
      dneg[0][k] <= qsq[RS][k][QW-1];
    end
    for (int j = 0; j < DS; j++) begin
      dn[j+1]    <= dn[j];
      dzero[j+1] <= dzero[j];
      dneg[j+1]  <= dneg[j];
      for (int k = 0; k < 4; k++) begin
        if (rem[j][k] >= dsh[j]) begin
          rem[j+1][k] <= rem[j][k] - dsh[j];
          quo[j+1][k] <= quo[j][k] | (UW'(1) << (QF - j));
        end else begin
          rem[j+1][k] <= rem[j][k];
          quo[j+1][k] <= quo[j][k];
        end
      end
    end
  end

  // ---- saturate, restore sign, output register
  logic [UW-1:0]        sat [4];
  logic signed [QB-1:0] comp [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sat[k]  = (quo[DS][k] > (UW'(1) << QF)) ? (UW'(1) << QF) : quo[DS][k];
      comp[k] = dneg[DS][k] ? -signed'({1'b0, sat[k]}) : signed'({1'b0, sat[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (dzero[DS]) begin
      // degenerate norm: identity rotation
      quat.quat_w <= e2q_pkg::Q_ONE;
      quat.quat_x <= '0;
      quat.quat_y <= '0;
      quat.quat_z <= '0;
    end else begin
      quat.quat_w <= comp[0];
      quat.quat_x <= comp[1];
      quat.quat_y <= comp[2];
      quat.quat_z <= comp[3];
    end
  end

  // ---- valid chain
  logic [2:0]  pv;
  logic [1:0]  sv;
  logic [RS:0] rv;
  logic [DS:0] dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv   <= '0;
      sv   <= '0;
      rv   <= '0;
      dv   <= '0;
      done <= 1'b0;
    end else begin
      pv   <= {pv[1:0], cv_r & cv_p & cv_y};
      sv   <= {sv[0], pv[2]};
      rv   <= {rv[RS-1:0], sv[1]};
      dv   <= {dv[DS-1:0], rv[RS]};
      done <= dv[DS];
    end
  end

endmodule

// ----- rtl/e2q_checker.sv -----
`timescale 1ns / 1ps

module e2q_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input e2q_pkg::quat_t quat
);

  // never refuses a transaction
  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy || !start)
    else $error("busy raised");

  // reset empties the pipeline
  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result right after reset");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (quat.quat_w <= e2q_pkg::Q_ONE && quat.quat_w >= -e2q_pkg::Q_ONE &&
              quat.quat_x <= e2q_pkg::Q_ONE && quat.quat_x >= -e2q_pkg::Q_ONE &&
              quat.quat_y <= e2q_pkg::Q_ONE && quat.quat_y >= -e2q_pkg::Q_ONE &&
              quat.quat_z <= e2q_pkg::Q_ONE && quat.quat_z >= -e2q_pkg::Q_ONE))
    else $error("component beyond one");

  // a unit quaternion is never all zero
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (quat.quat_w != '0 || quat.quat_x != '0 ||
              quat.quat_y != '0 || quat.quat_z != '0))
    else $error("zero quaternion");

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  // Drain time allowed beyond the result latency.
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int N_RANDOM     = 540;

  localparam longint PI_Q30_L      = 64'sd3373259426;
  localparam longint HALF_PI_Q30_L = 64'sd1686629713;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  e2q_pkg::angles_t angles;
  logic             done;
  e2q_pkg::quat_t   quat;

  euler_to_quaternion dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .angles (angles),
    .done   (done),
    .quat   (quat)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  e2q_pkg::angles_t pending_angles[$];
  e2q_pkg::quat_t   expected_quats[$];
  int               errors;
  int               cycle_count;
  int               calm_from;
  int               calm_to;
  bit               stim_done;

  // Arithmetic shift right, rounding toward minus infinity.
  function automatic longint shr_floor(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint atan_step(input int i);
    longint t[30];
    t = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
          64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
          64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
          64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
          64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
          64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};
    return t[i];
  endfunction

  // Half-angle cosine and sine, unscaled CORDIC gain, Q28 start vector.
  function automatic void half_angle_trig(input longint theta, output longint c,
                                          output longint s);
    bit     flip;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    flip = 1'b0;
    x = 64'sd1 <<< 28;
    y = 0;
    z = theta;
    while (z > HALF_PI_Q30_L) begin
      z -= PI_Q30_L;
      flip = !flip;
    end
    while (z < -HALF_PI_Q30_L) begin
      z += PI_Q30_L;
      flip = !flip;
    end
    for (int i = 0; i < e2q_pkg::CORDIC_STEPS; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_step(i);
      end else begin
        x += dx;
        y -= dy;
        z += atan_step(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned num);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > num) bitv >>= 2;
    while (bitv != 0) begin
      if (num >= res + bitv) begin
        num -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [e2q_pkg::QUAT_BITS-1:0] normalise(input longint q,
                                                              input longint unsigned n);
    longint unsigned one;
    longint unsigned mag;
    longint unsigned r;
    longint          v;
    one = 64'd1 << e2q_pkg::QUAT_FRAC;
    mag = (q < 0) ? -q : q;
    r = (mag * one + n / 2) / n;
    if (r > one) r = one;
    v = (q < 0) ? -longint'(r) : longint'(r);
    return v[e2q_pkg::QUAT_BITS-1:0];
  endfunction

  function automatic e2q_pkg::quat_t zyx_quaternion(input e2q_pkg::angles_t a);
    longint          cr, sr, cp, sp, cy, sy, pa, pb, pc, pd;
    longint          q[4];
    longint unsigned sum;
    longint unsigned n;
    e2q_pkg::quat_t  r;
    half_angle_trig(longint'(a.roll_angle) <<< e2q_pkg::HALF_SHIFT, cr, sr);
    half_angle_trig(longint'(a.pitch_angle) <<< e2q_pkg::HALF_SHIFT, cp, sp);
    half_angle_trig(longint'(a.yaw_angle) <<< e2q_pkg::HALF_SHIFT, cy, sy);
    pa = shr_floor(cy * cp, 28);
    pb = shr_floor(sy * sp, 28);
    pc = shr_floor(sy * cp, 28);
    pd = shr_floor(cy * sp, 28);
    q[0] = shr_floor(pa * cr + pb * sr, 28);
    q[1] = shr_floor(pa * sr - pb * cr, 28);
    q[2] = shr_floor(pc * sr + pd * cr, 28);
    q[3] = shr_floor(pc * cr - pd * sr, 28);
    sum = 0;
    for (int k = 0; k < 4; k++) sum += longint'(q[k] * q[k]);
    n = int_sqrt(sum);
    if (n == 0) begin
      r.quat_w = e2q_pkg::Q_ONE;
      r.quat_x = '0;
      r.quat_y = '0;
      r.quat_z = '0;
    end else begin
      r.quat_w = normalise(q[0], n);
      r.quat_x = normalise(q[1], n);
      r.quat_y = normalise(q[2], n);
      r.quat_z = normalise(q[3], n);
    end
    return r;
  endfunction

  function automatic e2q_pkg::angles_t mk_angles(input int r, input int p, input int y);
    e2q_pkg::angles_t a;
    a.roll_angle  = r[e2q_pkg::ANGLE_BITS-1:0];
    a.pitch_angle = p[e2q_pkg::ANGLE_BITS-1:0];
    a.yaw_angle   = y[e2q_pkg::ANGLE_BITS-1:0];
    return a;
  endfunction

  // Mostly uniform angles, with a share near zero, near +-pi and at the extremes.
  function automatic int pick_angle();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3) : -32768 + $urandom_range(0, 3);
      1: return $urandom_range(0, 64) - 32;
      2: return ($urandom_range(0, 1) ? 12868 : -12868) + $urandom_range(0, 8) - 4;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  initial begin
    int corners[7];
    corners = '{0, 1, -1, 32767, -32768, 12868, -12868};
    // Directed: each field alone at its corners, then all three together.
    foreach (corners[i]) begin
      pending_angles.push_back(mk_angles(corners[i], 0, 0));
      pending_angles.push_back(mk_angles(0, corners[i], 0));
      pending_angles.push_back(mk_angles(0, 0, corners[i]));
    end
    pending_angles.push_back(mk_angles(32767, 32767, 32767));
    pending_angles.push_back(mk_angles(-32768, -32768, -32768));
    pending_angles.push_back(mk_angles(6434, 6434, 6434));
    pending_angles.push_back(mk_angles(-6434, 25736, -19302));
    for (int i = 0; i < N_RANDOM; i++)
      pending_angles.push_back(mk_angles(pick_angle(), pick_angle(), pick_angle()));
  end

  // Back-to-back stretch in the middle of the random run.
  initial begin
    calm_from = 150;
    calm_to   = 300;
  end

  int accepted;

  // Driver: offers the head of the queue; a transaction goes when start && !busy.
  always @(posedge clk) begin
    bit go;
    if (rst) begin
      start    <= 1'b0;
      angles   <= '0;
      accepted <= 0;
    end else begin
      if (start && !busy) begin
        expected_quats.push_back(zyx_quaternion(angles));
        accepted <= accepted + 1;
      end
      if (start && busy) begin
        go = 1'b1;
      end else begin
        go = pending_angles.size() > 0 &&
             ((accepted >= calm_from && accepted < calm_to) || $urandom_range(0, 99) >= 12);
        if (go) angles <= pending_angles.pop_front();
      end
      start <= go;
    end
  end

  // Monitor: every done cycle carries one result.
  always @(posedge clk) begin
    e2q_pkg::quat_t exp_q;
    if (!rst && done) begin
      if (expected_quats.size() == 0) begin
        $display("%0t: result with none expected, actual %0d %0d %0d %0d", $time,
                 quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z);
        errors++;
      end else begin
        exp_q = expected_quats.pop_front();
        if (quat.quat_w !== exp_q.quat_w) begin
          $display("%0t: quat_w expected %0d actual %0d", $time, exp_q.quat_w, quat.quat_w);
          errors++;
        end
        if (quat.quat_x !== exp_q.quat_x) begin
          $display("%0t: quat_x expected %0d actual %0d", $time, exp_q.quat_x, quat.quat_x);
          errors++;
        end
        if (quat.quat_y !== exp_q.quat_y) begin
          $display("%0t: quat_y expected %0d actual %0d", $time, exp_q.quat_y, quat.quat_y);
          errors++;
        end
        if (quat.quat_z !== exp_q.quat_z) begin
          $display("%0t: quat_z expected %0d actual %0d", $time, exp_q.quat_z, quat.quat_z);
          errors++;
        end
      end
    end
  end

  // Run control: reset, wait for drain, then report.
  initial begin
    errors      = 0;
    cycle_count = 0;
    stim_done   = 1'b0;
    rst         = 1'b1;
    start       = 1'b0;
    angles      = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_angles.size() != 0 || start) @(posedge clk);
    @(posedge clk);
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_quats.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_quats.size());
      errors++;
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
